/* rtl/core/yuy2rgb_pkg.sv */
// Shared types and constants for the YUY2 / BGRX to RGB converter core.
// No dependencies; imported by every module of the core.
package yuy2rgb_pkg;

    // Width of the Q10 products and sums; holds every BT.601 sum with sign.
    localparam int PROD_W = 22;
    localparam int Q_SHIFT = 10;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] CHAN_MAX      = 8'd255;

    // Q10 coefficients (real value times 1024, rounded)
    localparam logic signed [PROD_W-1:0] K_Y  = 22'sd1192;
    localparam logic signed [PROD_W-1:0] K_RV = 22'sd1634;
    localparam logic signed [PROD_W-1:0] K_GU = 22'sd401;
    localparam logic signed [PROD_W-1:0] K_GV = 22'sd833;
    localparam logic signed [PROD_W-1:0] K_BU = 22'sd2065;

    localparam logic MODE_SWIZZLE = 1'b0;
    localparam logic MODE_YUY2    = 1'b1;

    typedef struct packed {
        logic [31:0] source_word;
        logic        second_pixel_present;
    } t_request;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_in_run;
    } t_result;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One pixel's worth of work handed from the sequencer to the arithmetic
    typedef struct packed {
        logic       valid;
        logic       yuv_mode;
        logic       last;
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        t_rgb       bgr;
    } t_pixel_req;

endpackage

/* rtl/core/yuy2rgb_sequencer.sv */
// Request register, mode register and pixel sequencing for the converter core.
// Depends on yuy2rgb_pkg.
module yuy2rgb_sequencer (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  yuy2rgb_pkg::t_request   i_request,
    input  logic                    i_cfg_wr_en,
    input  logic                    i_cfg_wr_data,
    output logic                    busy,
    output yuy2rgb_pkg::t_pixel_req o_pix
);
    import yuy2rgb_pkg::*;

    logic        r_pixel_mode;
    logic        r_valid;
    logic        r_phase;
    logic        r_second;
    logic [31:0] r_word;
    logic        n_valid;
    logic        n_phase;
    logic        accept;

    // Hold off new requests until the Y1 pixel of a two-pixel YUY2 request is issued
    assign busy   = r_valid & (r_pixel_mode == MODE_YUY2) & r_second & ~r_phase;
    assign accept = start & ~busy;

    always_comb begin
        n_valid = 1'b0;
        n_phase = 1'b0;
        if (accept) begin
            n_valid = 1'b1;
        end else if (busy) begin
            n_valid = 1'b1;
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= MODE_SWIZZLE;
            r_valid      <= 1'b0;
            r_phase      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pixel_mode <= i_cfg_wr_data;
            end
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= i_request.source_word;
            r_second <= i_request.second_pixel_present;
        end
    end

    always_comb begin
        o_pix.valid     = r_valid;
        o_pix.yuv_mode  = r_pixel_mode;
        o_pix.last      = ~busy;
        o_pix.luma      = r_phase ? r_word[23:16] : r_word[7:0];
        o_pix.cb        = r_word[15:8];
        o_pix.cr        = r_word[31:24];
        o_pix.bgr.red   = r_word[23:16];
        o_pix.bgr.green = r_word[15:8];
        o_pix.bgr.blue  = r_word[7:0];
    end

`ifndef NO_ASSERTIONS
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_swizzle_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pixel_mode == MODE_SWIZZLE) |-> !busy)
        else $error("busy raised in swizzle mode");

    a_second_pixel_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_pix.valid && o_pix.last))
        else $error("second pixel not issued as last of its request");
`endif

endmodule

/* rtl/core/yuy2rgb_pixel_calc.sv */
// Two-stage BT.601 Q10 pixel arithmetic (swizzle pixels pass through): product register,
// then sum, clamp and result register. Depends on yuy2rgb_pkg.
module yuy2rgb_pixel_calc (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  yuy2rgb_pkg::t_pixel_req i_pix,
    output logic                    o_strobe,
    output yuy2rgb_pkg::t_result    o_result
);
    import yuy2rgb_pkg::*;

    function automatic logic [7:0] sat_q10(input logic signed [PROD_W-1:0] sum);
        logic [7:0] res;
        if (sum[PROD_W-1]) begin
            res = 8'd0;
        end else if (|sum[PROD_W-2:Q_SHIFT+8]) begin
            res = CHAN_MAX;
        end else begin
            res = sum[Q_SHIFT+7:Q_SHIFT];
        end
        return res;
    endfunction

    logic [7:0]              c_luma;
    logic signed [8:0]       d_cb;
    logic signed [8:0]       e_cr;
    logic signed [PROD_W-1:0] c_ext;
    logic signed [PROD_W-1:0] d_ext;
    logic signed [PROD_W-1:0] e_ext;

    logic                     r_prod_valid;
    logic                     r_prod_yuv;
    logic                     r_prod_last;
    t_rgb                     r_prod_bgr;
    logic signed [PROD_W-1:0] r_py;
    logic signed [PROD_W-1:0] r_prv;
    logic signed [PROD_W-1:0] r_pgu;
    logic signed [PROD_W-1:0] r_pgv;
    logic signed [PROD_W-1:0] r_pbu;

    logic signed [PROD_W-1:0] sum_r;
    logic signed [PROD_W-1:0] sum_g;
    logic signed [PROD_W-1:0] sum_b;
    t_result                  n_result;
    logic                     r_strobe;
    t_result                  r_result;

    // Clamp luma offset at zero; chroma is centred on 128
    assign c_luma = (i_pix.luma > LUMA_OFFSET) ? (i_pix.luma - LUMA_OFFSET) : 8'd0;
    assign d_cb   = $signed({1'b0, i_pix.cb}) - $signed({1'b0, CHROMA_OFFSET});
    assign e_cr   = $signed({1'b0, i_pix.cr}) - $signed({1'b0, CHROMA_OFFSET});
    assign c_ext  = $signed({{(PROD_W-8){1'b0}}, c_luma});
    assign d_ext  = PROD_W'(d_cb);
    assign e_ext  = PROD_W'(e_cr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_yuv  <= i_pix.yuv_mode;
        r_prod_last <= i_pix.last;
        r_prod_bgr  <= i_pix.bgr;
        r_py        <= c_ext * K_Y;
        r_prv       <= e_ext * K_RV;
        r_pgu       <= d_ext * K_GU;
        r_pgv       <= e_ext * K_GV;
        r_pbu       <= d_ext * K_BU;
    end

    assign sum_r = r_py + r_prv;
    assign sum_g = r_py - r_pgu - r_pgv;
    assign sum_b = r_py + r_pbu;

    always_comb begin
        n_result.last_in_run = r_prod_last;
        if (r_prod_yuv == MODE_YUY2) begin
            n_result.red   = sat_q10(sum_r);
            n_result.green = sat_q10(sum_g);
            n_result.blue  = sat_q10(sum_b);
        end else begin
            n_result.red   = r_prod_bgr.red;
            n_result.green = r_prod_bgr.green;
            n_result.blue  = r_prod_bgr.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_req_to_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid |=> r_prod_valid)
        else $error("pixel request lost before product stage");

    a_prod_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_valid |=> o_strobe)
        else $error("product stage did not produce a result");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_prod_valid |=> !o_strobe)
        else $error("result strobe without a pixel in flight");
`endif

endmodule

/* rtl/core/yuy2_bgrx_to_rgba_converter_core.sv */
// An accepted request passes the request, product and result registers before its first pixel leaves.
// Throughput: one request per cycle in swizzle mode or for a lone YUY2 pixel; a YUY2 request
// with two pixels raises busy, and the next request waits while the one pixel datapath takes the second.
// One pixel per cycle leaves on o_result_strobe; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) clears all valid state and selects swizzle mode.
// Top level of the converter core; depends on yuy2rgb_pkg and its submodules.
module yuy2_bgrx_to_rgba_converter_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  yuy2rgb_pkg::t_request i_request,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    output logic                  busy,
    output logic                  o_result_strobe,
    output yuy2rgb_pkg::t_result  o_result
);
    import yuy2rgb_pkg::*;

    t_pixel_req pix;

    yuy2rgb_sequencer u_sequencer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_request     (i_request),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .busy          (busy),
        .o_pix         (pix)
    );

    yuy2rgb_pixel_calc u_pixel_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (pix),
        .o_strobe (o_result_strobe),
        .o_result (o_result)
    );

endmodule

/* dv/tb_yuy2_bgrx_to_rgba_converter_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for yuy2_bgrx_to_rgba_converter_core: swizzle and YUY2 pixels
// are predicted in the bench and compared field by field. Depends on yuy2rgb_pkg.
module tb_yuy2_bgrx_to_rgba_converter_core;
    import yuy2rgb_pkg::*;

    localparam int Q10_Y  = 1192;
    localparam int Q10_RV = 1634;
    localparam int Q10_GU = 401;
    localparam int Q10_GV = 833;
    localparam int Q10_BU = 2065;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int PRESSURE_PHASE  = 2;
    localparam int N_DIRECTED      = 17;

    localparam logic PHASE_MODE [N_PHASES] = '{MODE_SWIZZLE, MODE_YUY2, MODE_YUY2,
                                               MODE_SWIZZLE, MODE_YUY2, MODE_YUY2};
    localparam int PHASE_IDLE_PCT [N_PHASES] = '{0, 0, 50, 50, 23, 23};

    typedef struct packed {
        logic        mode;
        logic [31:0] word;
        logic        second;
        logic        typed;
        t_result     first_px;
        t_result     second_px;
    } t_stim_row;

    localparam t_result NO_PIXEL = '0;

    // Rows with typed=1 carry their pixels; the others go through the predictor.
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{MODE_SWIZZLE, 32'h0000_0000, 1'b0, 1'b1, t_result'{8'h00, 8'h00, 8'h00, 1'b1}, NO_PIXEL},
        '{MODE_SWIZZLE, 32'hFFFF_FFFF, 1'b1, 1'b1, t_result'{8'hFF, 8'hFF, 8'hFF, 1'b1}, NO_PIXEL},
        '{MODE_SWIZZLE, 32'h1122_3344, 1'b1, 1'b1, t_result'{8'h22, 8'h33, 8'h44, 1'b1}, NO_PIXEL},
        '{MODE_SWIZZLE, 32'hA5C3_E10F, 1'b0, 1'b1, t_result'{8'hC3, 8'hE1, 8'h0F, 1'b1}, NO_PIXEL},
        '{MODE_SWIZZLE, 32'h5A3C_1E78, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'h8010_8010, 1'b1, 1'b1, t_result'{8'h00, 8'h00, 8'h00, 1'b0},
                                                   t_result'{8'h00, 8'h00, 8'h00, 1'b1}},
        '{MODE_YUY2,    32'h8000_8000, 1'b1, 1'b1, t_result'{8'h00, 8'h00, 8'h00, 1'b0},
                                                   t_result'{8'h00, 8'h00, 8'h00, 1'b1}},
        '{MODE_YUY2,    32'h80EB_8010, 1'b0, 1'b1, t_result'{8'h00, 8'h00, 8'h00, 1'b1}, NO_PIXEL},
        '{MODE_YUY2,    32'h80EB_80EB, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'hFFFF_FFFF, 1'b0, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'h0000_0000, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'h00FF_00FF, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'hFF00_FF00, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'h80FF_80FF, 1'b0, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_YUY2,    32'h7F4C_817E, 1'b1, 1'b0, NO_PIXEL, NO_PIXEL},
        '{MODE_SWIZZLE, 32'h0102_0304, 1'b1, 1'b1, t_result'{8'h02, 8'h03, 8'h04, 1'b1}, NO_PIXEL}
    };

    logic     i_clk;
    logic     i_rst_n       = 1'b0;
    logic     start         = 1'b0;
    t_request i_request     = '0;
    logic     i_cfg_wr_en   = 1'b0;
    logic     i_cfg_wr_data = 1'b0;
    logic     busy;
    logic     o_result_strobe;
    t_result  o_result;

    t_result  expected_pixels [$];
    logic     pixel_mode_copy = MODE_SWIZZLE;
    int       mismatch_count  = 0;
    int       quiet_cycles    = 0;

    yuy2_bgrx_to_rgba_converter_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_request      (i_request),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .busy           (busy),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Drop negative sums, truncate the Q10 fraction, saturate at full scale.
    function automatic logic [7:0] clamp_q10(int sum);
        int scaled;
        scaled = sum >>> 10;
        if (sum < 0)
            return 8'd0;
        if (scaled > 255)
            return 8'hFF;
        return scaled[7:0];
    endfunction

    function automatic t_result yuv_pixel(logic [7:0] luma, logic [7:0] cb,
                                          logic [7:0] cr, logic last);
        int      c;
        int      d;
        int      e;
        t_result px;
        c = int'(luma) - 16;
        if (c < 0)
            c = 0;
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        px.red         = clamp_q10(Q10_Y * c + Q10_RV * e);
        px.green       = clamp_q10(Q10_Y * c - Q10_GU * d - Q10_GV * e);
        px.blue        = clamp_q10(Q10_Y * c + Q10_BU * d);
        px.last_in_run = last;
        return px;
    endfunction

    function automatic void predict_pixels(logic mode, t_request req);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        {b3, b2, b1, b0} = req.source_word;
        if (mode == MODE_SWIZZLE) begin
            expected_pixels.push_back(t_result'{b2, b1, b0, 1'b1});
        end else begin
            expected_pixels.push_back(yuv_pixel(b0, b1, b3, !req.second_pixel_present));
            if (req.second_pixel_present)
                expected_pixels.push_back(yuv_pixel(b2, b1, b3, 1'b1));
        end
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'h10;
            2: return 8'h80;
            3: return 8'hFF;
            4: return 8'($urandom_range(20));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_request random_request();
        t_request req;
        req.second_pixel_present = 1'($urandom_range(1));
        if ($urandom_range(3) == 0)
            req.source_word = {corner_byte(), corner_byte(), corner_byte(), corner_byte()};
        else
            req.source_word = $urandom;
        return req;
    endfunction

    // Hold the request until the block takes it, then record what it should produce.
    task automatic send_word(t_request req, logic typed, t_result px0, t_result px1);
        start     <= 1'b1;
        i_request <= req;
        do
            @(posedge i_clk);
        while (busy);
        if (typed) begin
            expected_pixels.push_back(px0);
            if (pixel_mode_copy == MODE_YUY2 && req.second_pixel_present)
                expected_pixels.push_back(px1);
        end else begin
            predict_pixels(pixel_mode_copy, req);
        end
    endtask

    // Drain the pipeline, then write the mode register.
    task automatic set_pixel_mode(logic mode);
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        pixel_mode_copy = mode;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        $display("%0t ERROR %s: got %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && $isunknown(o_result_strobe)) begin
            report_mismatch("unknown strobe", 8'hXX, 8'h00);
        end else if (i_rst_n && o_result_strobe) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", o_result.red, 8'hXX);
            end else begin
                want = expected_pixels.pop_front();
                if (o_result.red !== want.red)
                    report_mismatch("red", o_result.red, want.red);
                if (o_result.green !== want.green)
                    report_mismatch("green", o_result.green, want.green);
                if (o_result.blue !== want.blue)
                    report_mismatch("blue", o_result.blue, want.blue);
                if (o_result.last_in_run !== want.last_in_run)
                    report_mismatch("last_in_run", 8'(o_result.last_in_run),
                                    8'(want.last_in_run));
            end
        end
    end

    // Watchdog: restart the count whenever a request or a pixel moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("yuy2_bgrx_to_rgba_converter_core test failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_pixel_mode(MODE_SWIZZLE);

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].mode != pixel_mode_copy)
                set_pixel_mode(DIRECTED_ROWS[i].mode);
            send_word(t_request'{DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].second},
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].first_px,
                      DIRECTED_ROWS[i].second_px);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            set_pixel_mode(PHASE_MODE[phase]);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_word(random_request(), 1'b0, NO_PIXEL, NO_PIXEL);
                if (phase == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2) begin
                    // hold off until every outstanding pixel has come back
                    start <= 1'b0;
                    while (expected_pixels.size() != 0)
                        @(posedge i_clk);
                end else if ($urandom_range(99) < PHASE_IDLE_PCT[phase]) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end
            end
        end

        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("yuy2_bgrx_to_rgba_converter_core test passed");
        else
            $display("yuy2_bgrx_to_rgba_converter_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/yuy2rgb_pkg.sv
rtl/core/yuy2rgb_sequencer.sv
rtl/core/yuy2rgb_pixel_calc.sv
rtl/core/yuy2_bgrx_to_rgba_converter_core.sv
dv/tb_yuy2_bgrx_to_rgba_converter_core.sv
